@@ rtl/mot_pkg.sv @@
// Package for the moving object table: op codes, status codes, record, queue and state types, saturating add.
// No dependencies.
`timescale 1ns / 1ps
package mot_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DEL_IX = 3'd1,
    OP_DEL_SH = 3'd2,
    OP_TICK   = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BADIX = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  localparam int RecW = 32 * 10 + 8;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] roll;
    logic [31:0] rrate;
    logic [31:0] wd;
    logic [31:0] ht;
    logic [31:0] life;
    logic [7:0]  shape;
  } rec_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  index;
    logic [7:0]  shape;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] time_value;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] roll_rate;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [6:0]  object_count;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_roll;
    logic [31:0] out_width;
    logic [31:0] out_height;
    logic [7:0]  out_shape;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_MVRD,
    S_MVWR,
    S_DONE
  } st_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

@@ rtl/mot_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/mot_front.sv @@
// Front end: accepts input beats into a two-entry command queue.
// Depends on mot_pkg.
`timescale 1ns / 1ps
module mot_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mot_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_pop,
  output mot_pkg::cmd_t q_cmd
);
  import mot_pkg::*;

  cmd_t       buf_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = buf_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wp_r] <= in_cmd;
    end
  end
endmodule

@@ rtl/mot_back.sv @@
// Back end: executes table commands on the record RAM and holds the result beat.
// Depends on mot_pkg and mot_ram.
`timescale 1ns / 1ps
module mot_back #(
  parameter int MAX_OBJECTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  mot_pkg::cmd_t q_cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output mot_pkg::res_t res
);
  import mot_pkg::*;

  localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW = $clog2(MAX_OBJECTS + 1);

  st_t           st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  cmd_t          cmd_r;
  res_t          res_r, res_nxt;
  logic          rv_r, rv_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [5:0]    slot_r, slot_nxt;
  logic          rd_r, rd_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  rec_t          wdata, rdata;
  logic [CW-1:0] last;
  logic          rm;
  rec_t          upd;
  logic          ix_ok;

  mot_ram #(.WIDTH(RecW), .DEPTH(MAX_OBJECTS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign last      = cnt_r - 1'b1;
  assign res_valid = rv_r;
  assign res       = res_r;
  assign ix_ok     = (cnt_r != '0) && (32'(q_cmd.index) < 32'(cnt_r));

  always_comb begin
    upd      = rdata;
    upd.px   = sat_add(rdata.px, rdata.vx);
    upd.py   = sat_add(rdata.py, rdata.vy);
    upd.roll = sat_add(rdata.roll, rdata.rrate);
    rm       = 1'b0;
    if (cmd_r.op == OP_DEL_SH) begin
      rm = (rdata.shape == cmd_r.shape);
    end else if (rdata.life != 32'd0) begin
      if (cmd_r.time_value >= rdata.life) begin
        rm = 1'b1;
      end else begin
        upd.life = rdata.life - cmd_r.time_value;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_ADD, OP_READ: st_nxt = S_DONE;
            OP_DEL_IX: st_nxt = ix_ok ? S_MVRD : S_DONE;
            OP_DEL_SH, OP_TICK: st_nxt = S_RD;
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_RD:   st_nxt = (i_r >= cnt_r) ? S_DONE : S_EVAL;
      S_EVAL: st_nxt = (rm && (i_r != last)) ? S_MVRD : S_RD;
      S_MVRD: st_nxt = S_MVWR;
      S_MVWR: st_nxt = (cmd_r.op == OP_DEL_IX) ? S_DONE : S_RD;
      S_DONE: st_nxt = (rv_r && !res_ready) ? S_DONE : S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    we       = 1'b0;
    waddr    = i_r[AW-1:0];
    wdata    = upd;
    raddr    = i_r[AW-1:0];
    cnt_nxt  = cnt_r;
    i_nxt    = i_r;
    stat_nxt = stat_r;
    slot_nxt = slot_r;
    rd_nxt   = rd_r;
    rv_nxt   = rv_r && !res_ready;
    res_nxt  = res_r;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          stat_nxt = ST_OK;
          slot_nxt = '0;
          rd_nxt   = 1'b0;
          i_nxt    = '0;
          raddr    = AW'(q_cmd.index);
          case (q_cmd.op)
            OP_ADD: begin
              if (cnt_r >= CW'(MAX_OBJECTS)) begin
                stat_nxt = ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = cnt_r[AW-1:0];
                wdata    = '{px: q_cmd.pos_x, py: q_cmd.pos_y, pz: q_cmd.pos_z,
                             vx: q_cmd.vel_x, vy: q_cmd.vel_y, roll: '0,
                             rrate: q_cmd.roll_rate, wd: q_cmd.width,
                             ht: q_cmd.height, life: q_cmd.time_value,
                             shape: q_cmd.shape};
                slot_nxt = 6'(cnt_r);
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            OP_DEL_IX, OP_READ: begin
              if (cnt_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else if (!ix_ok) begin
                stat_nxt = ST_BADIX;
              end else if (q_cmd.op == OP_READ) begin
                rd_nxt = 1'b1;
              end else begin
                i_nxt   = CW'(q_cmd.index);
                raddr   = last[AW-1:0];
                cnt_nxt = last;
              end
            end
            OP_DEL_SH: begin
              if (cnt_r == '0) begin
                stat_nxt = ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        raddr = i_r[AW-1:0];
      end
      S_EVAL: begin
        if (rm) begin
          raddr   = last[AW-1:0];
          cnt_nxt = last;
        end else begin
          if (cmd_r.op == OP_TICK) begin
            we = 1'b1;
          end
          i_nxt = i_r + 1'b1;
        end
      end
      S_MVRD: begin
        raddr = cnt_r[AW-1:0];
      end
      S_MVWR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      S_DONE: begin
        if (!rv_r || res_ready) begin
          rv_nxt = 1'b1;
          res_nxt = '0;
          res_nxt.status = stat_r;
          res_nxt.slot = slot_r;
          res_nxt.object_count = 7'(cnt_r);
          if (rd_r) begin
            res_nxt.out_x      = rdata.px;
            res_nxt.out_y      = rdata.py;
            res_nxt.out_z      = rdata.pz;
            res_nxt.out_roll   = rdata.roll;
            res_nxt.out_width  = rdata.wd;
            res_nxt.out_height = rdata.ht;
            res_nxt.out_shape  = rdata.shape;
          end
        end
        raddr = AW'(cmd_r.index);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      rv_r  <= rv_nxt;
    end
    if (st_r == S_IDLE && q_valid) begin
      cmd_r <= q_cmd;
    end
    i_r    <= i_nxt;
    stat_r <= stat_nxt;
    slot_r <= slot_nxt;
    rd_r   <= rd_nxt;
    res_r  <= res_nxt;
  end
endmodule

@@ rtl/moving_object_table.sv @@
// Top level of the moving object table: stream ports, front queue, back engine.
// Depends on mot_pkg, mot_front, mot_back, mot_ram.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one command beat per accepted in_tvalid && in_tready.
//           in_tuser holds the operation; in_tdata the other fields.
//   out_* : one result beat per command, in command order.
//   Add, read, unused codes: go straight from the queue head to the done state.
//   Delete by index: the last record is moved into the freed slot first.
//   Tick and delete by shape: each entry is read, then evaluated; an entry
//   removed from the middle (not the last one) has the last record moved
//   into its place via the single RAM read port. Commands run one at a time.
//   A two-beat command queue keeps accepting while the engine works.
//   Reset empties the table and the queue; stored records need no clear.
//   When out_tready is low the result is held; the next command runs up
//   to its result and waits there, then the queue fills and drops in_tready.
module moving_object_table #(
  parameter int MAX_OBJECTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // operation
  // index, shape, pos_x, pos_y, pos_z, width, height, time_value, vel_x, vel_y, roll_rate, pad
  input  logic [303:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // status
  // slot, object_count, out_x, out_y, out_z, out_roll, out_width, out_height, out_shape, pad
  output logic [215:0] out_tdata
);
  import mot_pkg::*;

  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_pop;

  always_comb begin
    in_cmd            = '0;
    in_cmd.op         = in_tuser;
    in_cmd.index      = in_tdata[5:0];
    in_cmd.shape      = in_tdata[13:6];
    in_cmd.pos_x      = in_tdata[45:14];
    in_cmd.pos_y      = in_tdata[77:46];
    in_cmd.pos_z      = in_tdata[109:78];
    in_cmd.width      = in_tdata[141:110];
    in_cmd.height     = in_tdata[173:142];
    in_cmd.time_value = in_tdata[205:174];
    in_cmd.vel_x      = in_tdata[237:206];
    in_cmd.vel_y      = in_tdata[269:238];
    in_cmd.roll_rate  = in_tdata[301:270];
  end

  mot_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_cmd  (in_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_cmd   (q_cmd)
  );

  mot_back #(.MAX_OBJECTS(MAX_OBJECTS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {3'd0, res.out_shape, res.out_height, res.out_width, res.out_roll,
                      res.out_z, res.out_y, res.out_x, res.object_count, res.slot};
endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for moving_object_table: drives command beats, predicts each result
// with a behavioral table model held in a scoreboard class, and checks results.
// Depends on mot_pkg and the moving_object_table RTL.
`timescale 1ns / 1ps
module tb_top;
  import mot_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  index;
    logic [7:0]  shape;
    logic [31:0] pos_x, pos_y, pos_z, width, height, time_value, vel_x, vel_y, roll_rate;
  } cmd_s;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [6:0]  object_count;
    logic [31:0] ox, oy, oz, oroll, owidth, oheight;
    logic [7:0]  oshape;
  } res_s;

  typedef struct {
    logic [31:0] px, py, pz, vx, vy, roll, rrate, wd, ht, life;
    logic [7:0]  shape;
  } obj_s;

  class table_scoreboard;
    obj_s objs[64];
    int   count;
    res_s pending[$];
    int   mismatches;

    function void clear();
      count = 0;
      pending.delete();
      mismatches = 0;
    endfunction

    function logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
      logic signed [32:0] s;
      s = $signed({a[31], a}) + $signed({b[31], b});
      if (s > 33'sd2147483647) return 32'h7fff_ffff;
      if (s < -33'sd2147483648) return 32'h8000_0000;
      return s[31:0];
    endfunction

    function void swap_out(int i);
      if (i != count - 1) objs[i] = objs[count - 1];
      count--;
    endfunction

    function void note_cmd(cmd_s c);
      res_s r;
      int i;
      r = '0;
      case (c.op)
        OP_ADD: begin
          if (count >= 64) r.status = ST_FULL;
          else begin
            objs[count] = '{c.pos_x, c.pos_y, c.pos_z, c.vel_x, c.vel_y, 32'd0,
                            c.roll_rate, c.width, c.height, c.time_value, c.shape};
            r.slot = count[5:0];
            count++;
          end
        end
        OP_DEL_IX, OP_READ: begin
          if (count == 0) r.status = ST_EMPTY;
          else if (c.index >= count) r.status = ST_BADIX;
          else if (c.op == OP_DEL_IX) swap_out(c.index);
          else begin
            r.ox = objs[c.index].px; r.oy = objs[c.index].py; r.oz = objs[c.index].pz;
            r.oroll = objs[c.index].roll; r.owidth = objs[c.index].wd;
            r.oheight = objs[c.index].ht; r.oshape = objs[c.index].shape;
          end
        end
        OP_DEL_SH: begin
          if (count == 0) r.status = ST_EMPTY;
          else begin
            i = 0;
            while (i < count) if (objs[i].shape == c.shape) swap_out(i); else i++;
          end
        end
        OP_TICK: begin
          i = 0;
          while (i < count) begin
            bit gone;
            gone = 0;
            objs[i].px = sat32(objs[i].px, objs[i].vx);
            objs[i].py = sat32(objs[i].py, objs[i].vy);
            objs[i].roll = sat32(objs[i].roll, objs[i].rrate);
            if (objs[i].life != 0) begin
              if (c.time_value >= objs[i].life) gone = 1;
              else objs[i].life -= c.time_value;
            end
            if (gone) swap_out(i); else i++;
          end
        end
        default: ;
      endcase
      r.object_count = count[6:0];
      pending.push_back(r);
    endfunction

    function bit check_result(res_s a);
      res_s e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat status=%0d", a.status);
        return 0;
      end
      e = pending.pop_front();
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp st=%0d sl=%0d n=%0d x=%h y=%h z=%h r=%h w=%h h=%h s=%h",
                   e.status, e.slot, e.object_count, e.ox, e.oy, e.oz, e.oroll,
                   e.owidth, e.oheight, e.oshape);
          $display("         act st=%0d sl=%0d n=%0d x=%h y=%h z=%h r=%h w=%h h=%h s=%h",
                   a.status, a.slot, a.object_count, a.ox, a.oy, a.oz, a.oroll,
                   a.owidth, a.oheight, a.oshape);
        end
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [2:0]   in_tuser;
  logic [303:0] in_tdata;
  logic         out_tvalid, out_tready;
  logic [1:0]   out_tuser;
  logic [215:0] out_tdata;

  moving_object_table DUT (.*);

  table_scoreboard board;
  bit   stim_done;
  bit   hold_long;
  int   sent;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 8);
      3: return -$urandom_range(0, 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_s make_cmd(logic [2:0] op);
    cmd_s c;
    c.op = op; c.index = 6'($urandom);
    c.shape = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    c.pos_x = rnd_val(); c.pos_y = rnd_val(); c.pos_z = $urandom;
    c.width = $urandom; c.height = $urandom;
    c.vel_x = rnd_val(); c.vel_y = rnd_val(); c.roll_rate = rnd_val();
    case ($urandom_range(0, 3))
      0: c.time_value = 0;
      1: c.time_value = $urandom;
      default: c.time_value = $urandom_range(1, 200);
    endcase
    return c;
  endfunction

  task automatic send_beat(cmd_s c);
    in_tvalid <= 1;
    in_tuser  <= c.op;
    in_tdata  <= {2'd0, c.roll_rate, c.vel_y, c.vel_x, c.time_value, c.height, c.width,
                  c.pos_z, c.pos_y, c.pos_x, c.shape, c.index};
    do @(posedge clk); while (!in_tready);
    board.note_cmd(c);
    sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic send_burst(cmd_s c);
    send_beat(c);
    if ($urandom_range(0, 4) == 0) pause_sender();
  endtask

  initial begin
    cmd_s c;
    int   k;
    board = new();
    board.clear();
    rst_n = 0; in_tvalid = 0; in_tuser = '0; in_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: empty table cases, fill, full, extremes, unused codes
    c = make_cmd(OP_READ);      send_beat(c);
    c = make_cmd(OP_DEL_IX);    send_beat(c);
    c = make_cmd(OP_DEL_SH);    send_beat(c);
    c = make_cmd(OP_TICK);      send_beat(c);
    c = make_cmd(OP_UNUSED_LO); send_beat(c);
    c = make_cmd(OP_UNUSED_HI); send_beat(c);
    c = make_cmd(OP_ADD);
    c.pos_x = 32'h7fff_fff0; c.vel_x = 32'h7fff_ffff; c.pos_y = 32'h8000_0010;
    c.vel_y = 32'h8000_0000; c.roll_rate = 32'h7fff_ffff; c.time_value = 0;
    c.shape = 8'hff; c.width = '1; c.height = '1;
    send_beat(c);
    c = make_cmd(OP_TICK);   c.time_value = '1; send_beat(c);
    c = make_cmd(OP_TICK);   send_beat(c);
    c = make_cmd(OP_READ);   c.index = 0; send_beat(c);
    c = make_cmd(OP_READ);   c.index = 63; send_beat(c);
    hold_long = 1;
    for (k = 0; k < 66; k++) begin
      c = make_cmd(OP_ADD); c.time_value = (k % 3 == 0) ? 32'd5 : 32'd0; send_beat(c);
    end
    hold_long = 0;
    c = make_cmd(OP_READ);   c.index = 63; send_beat(c);
    c = make_cmd(OP_DEL_IX); c.index = 63; send_beat(c);
    c = make_cmd(OP_DEL_IX); c.index = 63; send_beat(c);
    c = make_cmd(OP_TICK);   c.time_value = 5; send_beat(c);
    c = make_cmd(OP_DEL_SH); c.shape = 8'd200; send_beat(c);
    c = make_cmd(OP_DEL_SH); c.shape = 8'd1; send_beat(c);
    // random
    for (k = 0; k < 1300; k++) begin
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) c = make_cmd(OP_ADD);
      else if (p < 55) c = make_cmd(OP_READ);
      else if (p < 68) c = make_cmd(OP_DEL_IX);
      else if (p < 74) c = make_cmd(OP_DEL_SH);
      else if (p < 97) c = make_cmd(OP_TICK);
      else c = make_cmd(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)));
      if ((c.op == OP_READ || c.op == OP_DEL_IX) && board.count > 0 && p % 4 != 0)
        c.index = 6'($urandom_range(0, board.count - 1));
      send_burst(c);
    end
    in_tvalid <= 0;
    stim_done = 1;
  end

  initial begin
    int stall_ct;
    bit held;
    out_tready = 0;
    held = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_long && !held) begin
        out_tready <= 0;
        for (stall_ct = 0; stall_ct < 300; stall_ct++) @(negedge clk);
        held = 1;
      end
      out_tready <= ($urandom_range(0, 3) != 0) || (sent % 200 > 150);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    res_s a;
    if (rst_n && out_tvalid && out_tready) begin
      a.status = out_tuser;
      {a.oshape, a.oheight, a.owidth, a.oroll, a.oz, a.oy, a.ox, a.object_count, a.slot} =
        out_tdata[212:0];
      void'(board.check_result(a));
    end
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
